>>> rtl/c8x_pkg.sv
// shared types and constants for the chip8 executor
package c8x_pkg;

  localparam int unsigned ADDR_W = 12;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EXEC = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam int unsigned FONT_BYTES = 80;

  // result of one command
  typedef struct packed {
    logic [11:0] pc;
    logic        draw;
    logic        waiting_key;
    logic        invalid_opcode;
    logic        sound_on;
    logic [63:0] display_row;
  } result_t;

  // font glyph table
  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] glyphs [0:79];
    glyphs = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };
    if (idx < 7'd80) begin
      return glyphs[idx];
    end
    return 8'h00;
  endfunction

endpackage

>>> rtl/chip8_instruction_executor_unit.sv
// chip8 executor top level: command sequencer over main memory and frame buffer
//
// usage: one item on the input channel (in_valid/in_stall) carries a command:
// load a memory byte, execute the instruction at pc, or read a display row.
// every item gives exactly one result item on the output channel
// (out_valid/out_stall) with the pc after the command, the draw, waiting_key,
// invalid_opcode and sound_on flags and, for a read, the addressed row.
// a sprite, 00E0, Fx55 and Fx65 step through their rows or registers in turn,
// each step going through the one read port and one write port of the main
// memory and frame buffer. one item is at work at a time. after reset a
// clearing pass writes the font to bytes 0-79 and zero to the rest of memory
// and to all 32 frame buffer rows, during which no item is accepted. while a
// result is held under out_stall the next item is taken but waits at its last
// step, writing nothing, until delivery.
module chip8_instruction_executor_unit #(
  parameter int unsigned MEM_BYTES     = 4096,
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned SCREEN_WIDTH  = 64,
  parameter int unsigned SCREEN_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_keys,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pc,
  output logic        out_draw,
  output logic        out_waiting_key,
  output logic        out_invalid_opcode,
  output logic        out_sound_on,
  output logic [SCREEN_WIDTH-1:0] out_display_row
);
  import c8x_pkg::*;

  localparam int unsigned MA_W = $clog2(MEM_BYTES);
  localparam int unsigned SP_W = $clog2(STACK_DEPTH);
  localparam int unsigned RY_W = $clog2(SCREEN_HEIGHT);
  localparam int unsigned XW_W = $clog2(SCREEN_WIDTH);

  // sequencer states
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_OUT   = 5'd2;
  localparam logic [4:0] S_RDW   = 5'd3;
  localparam logic [4:0] S_RDR   = 5'd4;
  localparam logic [4:0] S_F0    = 5'd5;
  localparam logic [4:0] S_F1    = 5'd6;
  localparam logic [4:0] S_F2    = 5'd7;
  localparam logic [4:0] S_EX    = 5'd8;
  localparam logic [4:0] S_CLS   = 5'd9;
  localparam logic [4:0] S_SPA   = 5'd10;
  localparam logic [4:0] S_SPB   = 5'd11;
  localparam logic [4:0] S_SPC   = 5'd12;
  localparam logic [4:0] S_SPD   = 5'd13;
  localparam logic [4:0] S_BCD   = 5'd14;
  localparam logic [4:0] S_STO   = 5'd15;
  localparam logic [4:0] S_LDA   = 5'd16;
  localparam logic [4:0] S_LDB   = 5'd17;
  localparam logic [4:0] S_RET   = 5'd18;
  localparam logic [4:0] S_RETW  = 5'd19;

  logic [4:0] state_r, state_nxt;

  // memories
  logic [7:0]              mem [0:MEM_BYTES-1];
  logic [SCREEN_WIDTH-1:0] fb  [0:SCREEN_HEIGHT-1];
  logic [11:0]             stk [0:STACK_DEPTH-1];

  logic            mem_we;
  logic [MA_W-1:0] mem_wa, mem_ra;
  logic [7:0]      mem_wd, mem_rd_r;
  logic            fb_we;
  logic [RY_W-1:0] fb_wa, fb_ra;
  logic [SCREEN_WIDTH-1:0] fb_wd, fb_rd_r;
  logic            stk_we;
  logic [SP_W-1:0] stk_a;
  logic [11:0]     stk_wd, stk_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb[fb_wa] <= fb_wd;
    end
    fb_rd_r <= fb[fb_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_a] <= stk_wd;
    end
    stk_rd_r <= stk[stk_a];
  end

  // architectural registers
  logic [7:0]      v_r [0:15];
  logic [7:0]      v_nxt [0:15];
  logic [15:0]     i_r, i_nxt;
  logic [11:0]     pc_r, pc_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [7:0]      dt_r, dt_nxt, st_r, st_nxt;

  // item and work registers
  logic [1:0]  cmd_r, cmd_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [15:0] op_r, op_nxt;
  logic [MA_W-1:0] cnt_r, cnt_nxt;
  logic [4:0]  row_r, row_nxt;
  logic        hit_r, hit_nxt;
  logic [SCREEN_WIDTH-1:0] bits_r, bits_nxt;
  logic [7:0]  bcd_r, bcd_nxt;
  result_t     res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic [3:0] ox, oy, on;
  logic [7:0] vx, vy, kk;
  logic [11:0] nnn;
  assign ox  = op_r[11:8];
  assign oy  = op_r[7:4];
  assign on  = op_r[3:0];
  assign kk  = op_r[7:0];
  assign nnn = op_r[11:0];
  assign vx  = v_r[ox];
  assign vy  = v_r[oy];

  logic accept;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  assign out_pc             = res_r.pc;
  assign out_draw           = res_r.draw;
  assign out_waiting_key    = res_r.waiting_key;
  assign out_invalid_opcode = res_r.invalid_opcode;
  assign out_sound_on       = res_r.sound_on;
  assign out_display_row    = res_r.display_row[SCREEN_WIDTH-1:0];

  // sprite geometry
  logic [XW_W-1:0] xpos;
  logic [RY_W-1:0] ypos;
  logic [5:0]      yabs;
  assign xpos = vx[XW_W-1:0];
  assign ypos = vy[RY_W-1:0];
  assign yabs = {1'b0, ypos} + {1'b0, row_r};

  // highest pressed key
  logic [3:0] key_hi;
  always_comb begin
    key_hi = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (keys_r[k]) begin
        key_hi = 4'(k);
      end
    end
  end

  // decimal digits: compare and subtract for hundreds, reciprocal for tens
  logic [1:0]  bcd_hun;
  logic [7:0]  bcd_rem;
  logic [15:0] bcd_mul;
  logic [3:0]  bcd_ten, bcd_one;
  always_comb begin
    if (bcd_r >= 8'd200) begin
      bcd_hun = 2'd2;
      bcd_rem = bcd_r - 8'd200;
    end else if (bcd_r >= 8'd100) begin
      bcd_hun = 2'd1;
      bcd_rem = bcd_r - 8'd100;
    end else begin
      bcd_hun = 2'd0;
      bcd_rem = bcd_r;
    end
    bcd_mul = {8'd0, bcd_rem} * 16'd205;
    bcd_ten = bcd_mul[14:11];
    bcd_one = 4'(bcd_rem - {1'b0, bcd_ten, 3'd0} - {3'd0, bcd_ten, 1'b0});
  end

  logic [12:0] pc_p2, pc_p4;
  assign pc_p2 = {1'b0, pc_r} + 13'd2;
  assign pc_p4 = {1'b0, pc_r} + 13'd4;

  logic [8:0] add9;
  assign add9 = {1'b0, vx} + {1'b0, vy};

  logic key_vx;
  assign key_vx = (vx < 8'd16) && keys_r[vx[3:0]];

  // finish helper values
  logic        fin;
  logic [11:0] fin_pc;
  logic        fin_draw, fin_wait, fin_inv;

  always_comb begin
    state_nxt  = state_r;
    for (int k = 0; k < 16; k++) begin
      v_nxt[k] = v_r[k];
    end
    i_nxt   = i_r;
    pc_nxt  = pc_r;
    sp_nxt  = sp_r;
    dt_nxt  = dt_r;
    st_nxt  = st_r;
    cmd_nxt = cmd_r;
    addr_nxt = addr_r;
    data_nxt = data_r;
    keys_nxt = keys_r;
    rnd_nxt  = rnd_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    row_nxt  = row_r;
    hit_nxt  = hit_r;
    bits_nxt = bits_r;
    bcd_nxt  = bcd_r;
    res_nxt  = res_r;
    ovalid_nxt = ovalid_r;
    mem_we = 1'b0;
    mem_wa = cnt_r;
    mem_wd = 8'h00;
    mem_ra = pc_r[MA_W-1:0];
    fb_we  = 1'b0;
    fb_wa  = cnt_r[RY_W-1:0];
    fb_wd  = '0;
    fb_ra  = addr_r[RY_W-1:0];
    stk_we = 1'b0;
    stk_a  = sp_r;
    stk_wd = pc_p2[11:0];
    fin      = 1'b0;
    fin_pc   = pc_r;
    fin_draw = 1'b0;
    fin_wait = 1'b0;
    fin_inv  = 1'b0;

    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      // clearing pass: font then zero, frame buffer rows alongside
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = (cnt_r < MA_W'(FONT_BYTES)) ? font_byte(cnt_r[6:0]) : 8'h00;
        fb_we  = (cnt_r < MA_W'(SCREEN_HEIGHT));
        fb_wa  = cnt_r[RY_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MA_W'(MEM_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_cmd;
          addr_nxt = in_address;
          data_nxt = in_data;
          keys_nxt = in_keys;
          rnd_nxt  = in_random_byte;
          case (in_cmd)
            CMD_EXEC: state_nxt = S_F0;
            CMD_READ: state_nxt = S_RDW;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      // load write, or unknown command
      S_OUT: begin
        if (cmd_r == CMD_LOAD) begin
          mem_we = 1'b1;
          mem_wa = addr_r[MA_W-1:0];
          mem_wd = data_r;
        end
        fin = 1'b1;
      end
      S_RDW: begin
        fb_ra = addr_r[RY_W-1:0];
        state_nxt = S_RDR;
      end
      S_RDR: begin
        fin = 1'b1;
      end
      // fetch two opcode bytes
      S_F0: begin
        mem_ra = pc_r[MA_W-1:0];
        state_nxt = S_F1;
      end
      S_F1: begin
        mem_ra = MA_W'(pc_r + 12'd1);
        op_nxt[15:8] = mem_rd_r;
        state_nxt = S_F2;
      end
      S_F2: begin
        op_nxt[7:0] = mem_rd_r;
        state_nxt = S_EX;
        cnt_nxt = '0;
        row_nxt = '0;
        hit_nxt = 1'b0;
      end
      S_EX: begin
        fin = 1'b1;
        fin_pc = pc_p2[11:0];
        unique case (op_r[15:12])
          4'h0: begin
            if (nnn == 12'h0EE) begin
              fin = 1'b0;
              sp_nxt = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;
              state_nxt = S_RET;
            end else if (nnn == 12'h0E0) begin
              fin = 1'b0;
              state_nxt = S_CLS;
            end else begin
              fin_pc = nnn;
            end
          end
          4'h1: fin_pc = nnn;
          4'h2: begin
            stk_we = 1'b1;
            stk_a  = sp_r;
            stk_wd = pc_p2[11:0];
            sp_nxt = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
            fin_pc = nnn;
          end
          4'h3: if (vx == kk) fin_pc = pc_p4[11:0];
          4'h4: if (vx != kk) fin_pc = pc_p4[11:0];
          4'h5: if (vx == vy) fin_pc = pc_p4[11:0];
          4'h6: v_nxt[ox] = kk;
          4'h7: v_nxt[ox] = vx + kk;
          4'h8: begin
            case (on)
              4'h0: v_nxt[ox] = vy;
              4'h1: begin v_nxt[ox] = vx | vy; v_nxt[15] = 8'h00; end
              4'h2: begin v_nxt[ox] = vx & vy; v_nxt[15] = 8'h00; end
              4'h3: begin v_nxt[ox] = vx ^ vy; v_nxt[15] = 8'h00; end
              4'h4: begin v_nxt[ox] = add9[7:0]; v_nxt[15] = {7'd0, add9[8]}; end
              4'h5: begin v_nxt[ox] = vx - vy; v_nxt[15] = {7'd0, vx > vy}; end
              4'h6: begin v_nxt[ox] = vx >> 1; v_nxt[15] = {7'd0, vx[0]}; end
              4'h7: begin v_nxt[ox] = vy - vx; v_nxt[15] = {7'd0, vy > vx}; end
              4'hE: begin v_nxt[ox] = vx << 1; v_nxt[15] = {7'd0, vx[7]}; end
              default: fin_inv = 1'b1;
            endcase
          end
          4'h9: if (vx != vy) fin_pc = pc_p4[11:0];
          4'hA: i_nxt = {4'd0, nnn};
          4'hB: fin_pc = nnn + {4'd0, v_r[0]};
          4'hC: v_nxt[ox] = rnd_r & kk;
          4'hD: begin
            fin = 1'b0;
            state_nxt = S_SPA;
          end
          4'hE: begin
            if (kk == 8'h9E) begin
              if (key_vx) fin_pc = pc_p4[11:0];
            end else if (kk == 8'hA1) begin
              if (!key_vx) fin_pc = pc_p4[11:0];
            end else begin
              fin_inv = 1'b1;
            end
          end
          default: begin
            case (kk)
              8'h07: v_nxt[ox] = dt_r;
              8'h0A: begin
                if (keys_r == 16'd0) begin
                  fin_pc = pc_r;
                  fin_wait = 1'b1;
                end else begin
                  v_nxt[ox] = {4'd0, key_hi};
                end
              end
              8'h15: dt_nxt = vx;
              8'h18: st_nxt = vx;
              8'h1E: i_nxt = i_r + {8'd0, vx};
              8'h29: i_nxt = {8'd0, vx} * 16'd5;
              8'h33: begin
                fin = 1'b0;
                bcd_nxt = vx;
                state_nxt = S_BCD;
              end
              8'h55: begin
                fin = 1'b0;
                state_nxt = S_STO;
              end
              8'h65: begin
                fin = 1'b0;
                state_nxt = S_LDA;
              end
              default: ;
            endcase
          end
        endcase
      end
      // return: read stack at decremented pointer
      S_RET: begin
        stk_a = sp_r;
        state_nxt = S_RETW;
      end
      S_RETW: begin
        fin = 1'b1;
        fin_pc = stk_rd_r;
      end
      // clear screen one row a cycle; the last row waits while an earlier result is stalled
      S_CLS: begin
        fb_we = 1'b1;
        fb_wa = cnt_r[RY_W-1:0];
        fb_wd = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MA_W'(SCREEN_HEIGHT - 1)) begin
          fin = 1'b1;
          fin_pc = pc_p2[11:0];
          fin_draw = 1'b1;
        end
      end
      // sprite: read byte and row, then xor back
      S_SPA: begin
        if ({1'b0, row_r} >= {2'b0, on} || yabs >= 6'(SCREEN_HEIGHT)) begin
          v_nxt[15] = {7'd0, hit_r};
          fin = 1'b1;
          fin_pc = pc_p2[11:0];
          fin_draw = 1'b1;
        end else begin
          mem_ra = MA_W'(i_r + {11'd0, row_r});
          fb_ra  = yabs[RY_W-1:0];
          state_nxt = S_SPB;
        end
      end
      S_SPB: begin
        fb_ra = yabs[RY_W-1:0];
        bits_nxt = {mem_rd_r, {(SCREEN_WIDTH-8){1'b0}}} >> xpos;
        state_nxt = S_SPC;
      end
      S_SPC: begin
        fb_we = 1'b1;
        fb_wa = yabs[RY_W-1:0];
        fb_wd = fb_rd_r ^ bits_r;
        if ((fb_rd_r & bits_r) != '0) begin
          hit_nxt = 1'b1;
        end
        row_nxt = row_r + 1'b1;
        state_nxt = S_SPA;
      end
      // bcd: three writes
      S_BCD: begin
        mem_we = 1'b1;
        mem_wa = MA_W'(i_r + {4'd0, cnt_r[11:0]});
        case (cnt_r[1:0])
          2'd0:    mem_wd = {6'd0, bcd_hun};
          2'd1:    mem_wd = {4'd0, bcd_ten};
          default: mem_wd = {4'd0, bcd_one};
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd2) begin
          fin = 1'b1;
          fin_pc = pc_p2[11:0];
        end
      end
      // store v0..vx
      S_STO: begin
        mem_we = 1'b1;
        mem_wa = MA_W'(i_r + {4'd0, cnt_r[11:0]});
        mem_wd = v_r[cnt_r[3:0]];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == ox) begin
          i_nxt = i_r + {12'd0, ox} + 16'd1;
          fin = 1'b1;
          fin_pc = pc_p2[11:0];
        end
      end
      // load v0..vx
      S_LDA: begin
        mem_ra = MA_W'(i_r + {4'd0, cnt_r[11:0]});
        state_nxt = S_LDB;
      end
      S_LDB: begin
        v_nxt[cnt_r[3:0]] = mem_rd_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == ox) begin
          i_nxt = i_r + {12'd0, ox} + 16'd1;
          fin = 1'b1;
          fin_pc = pc_p2[11:0];
        end else begin
          state_nxt = S_LDA;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // deliver the result item
    if (fin) begin
      state_nxt = S_IDLE;
      ovalid_nxt = 1'b1;
      res_nxt.draw = fin_draw;
      res_nxt.waiting_key = fin_wait;
      res_nxt.invalid_opcode = fin_inv;
      res_nxt.display_row = '0;
      if (cmd_r == CMD_EXEC) begin
        pc_nxt = fin_pc;
        res_nxt.pc = fin_pc;
      end else begin
        res_nxt.pc = pc_r;
      end
      if (cmd_r == CMD_READ) begin
        res_nxt.display_row = 64'(fb_rd_r);
      end
      res_nxt.sound_on = (st_nxt != 8'd0);
    end
    // hold off finishing while a result waits
    if (fin && ovalid_r && out_stall) begin
      state_nxt = state_r;
      ovalid_nxt = 1'b1;
      res_nxt = res_r;
      pc_nxt = pc_r;
      for (int k = 0; k < 16; k++) begin
        v_nxt[k] = v_r[k];
      end
      i_nxt = i_r;
      sp_nxt = sp_r;
      dt_nxt = dt_r;
      st_nxt = st_r;
      cnt_nxt = cnt_r;
      row_nxt = row_r;
      mem_we = 1'b0;
      fb_we = 1'b0;
      stk_we = 1'b0;
      fb_ra = fb_wa;
      if (state_r == S_RETW) begin
        stk_a = sp_r;
      end
      if (state_r == S_RDR) begin
        fb_ra = addr_r[RY_W-1:0];
      end
      if (state_r == S_LDB) begin
        mem_ra = MA_W'(i_r + {4'd0, cnt_r[11:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      pc_r     <= PC_RESET;
      i_r      <= '0;
      sp_r     <= '0;
      dt_r     <= '0;
      st_r     <= '0;
      for (int k = 0; k < 16; k++) begin
        v_r[k] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      pc_r     <= pc_nxt;
      i_r      <= i_nxt;
      sp_r     <= sp_nxt;
      dt_r     <= dt_nxt;
      st_r     <= st_nxt;
      for (int k = 0; k < 16; k++) begin
        v_r[k] <= v_nxt[k];
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    keys_r <= keys_nxt;
    rnd_r  <= rnd_nxt;
    op_r   <= op_nxt;
    row_r  <= row_nxt;
    hit_r  <= hit_nxt;
    bits_r <= bits_nxt;
    bcd_r  <= bcd_nxt;
    res_r  <= res_nxt;
  end

  // a waiting result holds its pc
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pc))
    else $error("result changed while stalled");
  // no item taken during the clearing pass
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> in_stall)
    else $error("item taken while clearing");
  // a draw result carries neither waiting_key nor invalid_opcode and no row
  a_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_draw |-> !out_waiting_key && !out_invalid_opcode &&
      out_display_row == '0)
    else $error("draw result with other flags");
endmodule
